### sv/rcpc_pkg.sv
// Shared types, register indexes, color codes and reset values of the pixel counter.
`default_nettype none

package rcpc_pkg;

  localparam int LEVEL_W = 8;
  localparam int TOTAL_W = 16;
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 3;

  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [TOTAL_W-1:0] total_t;
  typedef logic [CFG_W-1:0]   cfg_data_t;
  typedef logic [IDX_W-1:0]   reg_idx_t;
  typedef logic [1:0]         color_t;

  // Register map.
  localparam reg_idx_t REG_GREEN_LEVEL_MIN = 3'd0;
  localparam reg_idx_t REG_RED_LEVEL_MIN   = 3'd1;
  localparam reg_idx_t REG_BLUE_LEVEL_MIN  = 3'd2;
  localparam reg_idx_t REG_GREEN_COUNT_MIN = 3'd3;
  localparam reg_idx_t REG_RED_COUNT_MIN   = 3'd4;
  localparam reg_idx_t REG_BLUE_COUNT_MIN  = 3'd5;

  // Class codes, in priority order.
  localparam color_t COLOR_NONE  = 2'd0;
  localparam color_t COLOR_GREEN = 2'd1;
  localparam color_t COLOR_RED   = 2'd2;
  localparam color_t COLOR_BLUE  = 2'd3;

  // Register reset values.
  localparam level_t GREEN_LEVEL_RST = 8'd90;
  localparam level_t RED_LEVEL_RST   = 8'd90;
  localparam level_t BLUE_LEVEL_RST  = 8'd150;
  localparam total_t GREEN_COUNT_RST = 16'd200;
  localparam total_t RED_COUNT_RST   = 16'd200;
  localparam total_t BLUE_COUNT_RST  = 16'd230;

  // Dominance test: dom above level and each other channel below 0.6 * dom,
  // done exactly as 5*other < 3*dom on 11-bit products.
  function automatic logic is_dominant(level_t dom, level_t o1, level_t o2, level_t lvl);
    logic [10:0] dom3;
    logic [10:0] o1_5;
    logic [10:0] o2_5;
    dom3 = 11'(dom) + 11'({dom, 1'b0});
    o1_5 = 11'(o1) + 11'({o1, 2'b00});
    o2_5 = 11'(o2) + 11'({o2, 2'b00});
    return (dom > lvl) && (o1_5 < dom3) && (o2_5 < dom3);
  endfunction

endpackage

`default_nettype wire

### sv/rgb_color_pixel_counter.sv
// Top level: RGB pixel classifier with per-frame saturating color counters.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------------------
//   in_     | in        | in_valid / in_stall  | red/green/blue level, frame_end
//   out_    | out       | out_valid / out_stall| detected_color, green/red/blue totals
//   cfg_    | in        | cfg_we               | cfg_index, cfg_data (six registers)
//
// One pixel is taken every cycle while in_stall is low. A pixel lands in the input
// register and is classified and counted as it leaves it; a frame_end pixel loads
// the result register as it leaves, and it stays held while out_stall keeps a result.
// rst_n is synchronous and clears the counters, valids and config registers to defaults.
// in_stall rises only while a frame_end pixel sits in the input register and the
// result register still holds an untaken result that out_stall keeps.
`default_nettype none

module rgb_color_pixel_counter #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // configuration
  input  wire logic                cfg_we,
  input  wire rcpc_pkg::reg_idx_t  cfg_index,
  input  wire rcpc_pkg::cfg_data_t cfg_data,
  // pixel stream
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire rcpc_pkg::level_t    in_red_level,
  input  wire rcpc_pkg::level_t    in_green_level,
  input  wire rcpc_pkg::level_t    in_blue_level,
  input  wire logic                in_frame_end,
  // frame result
  output logic                     out_valid,
  input  wire logic                out_stall,
  output rcpc_pkg::color_t         out_detected_color,
  output rcpc_pkg::total_t         out_green_total,
  output rcpc_pkg::total_t         out_red_total,
  output rcpc_pkg::total_t         out_blue_total
);
  import rcpc_pkg::*;

  // Compare width: wide enough for both the count and a 16-bit minimum.
  localparam int CMP_W = (COUNT_BITS > TOTAL_W) ? COUNT_BITS : TOTAL_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef logic [COUNT_BITS-1:0] count_t;

  // Configuration registers.
  level_t green_level_min_r, red_level_min_r, blue_level_min_r;
  total_t green_count_min_r, red_count_min_r, blue_count_min_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      green_level_min_r <= GREEN_LEVEL_RST;
      red_level_min_r   <= RED_LEVEL_RST;
      blue_level_min_r  <= BLUE_LEVEL_RST;
      green_count_min_r <= GREEN_COUNT_RST;
      red_count_min_r   <= RED_COUNT_RST;
      blue_count_min_r  <= BLUE_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GREEN_LEVEL_MIN: green_level_min_r <= cfg_data[LEVEL_W-1:0];
        REG_RED_LEVEL_MIN:   red_level_min_r   <= cfg_data[LEVEL_W-1:0];
        REG_BLUE_LEVEL_MIN:  blue_level_min_r  <= cfg_data[LEVEL_W-1:0];
        REG_GREEN_COUNT_MIN: green_count_min_r <= cfg_data;
        REG_RED_COUNT_MIN:   red_count_min_r   <= cfg_data;
        REG_BLUE_COUNT_MIN:  blue_count_min_r  <= cfg_data;
        default: ;  // drop writes to unmapped indexes
      endcase
    end
  end

  // Input register.
  logic   s1_valid_r;
  logic   s1_frame_end_r;
  level_t s1_red_r, s1_green_r, s1_blue_r;

  logic out_free;   // result register can take a new result this cycle
  logic s1_adv;     // input register item moves on at this edge
  logic in_xfer;

  assign out_free = !out_valid || !out_stall;
  assign s1_adv   = s1_valid_r && (!s1_frame_end_r || out_free);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_red_r       <= in_red_level;
      s1_green_r     <= in_green_level;
      s1_blue_r      <= in_blue_level;
      s1_frame_end_r <= in_frame_end;
    end
  end

  // Classify the held pixel and bump the matching counters.
  logic   hit_green, hit_red, hit_blue;
  count_t green_tally_r, red_tally_r, blue_tally_r;
  count_t green_cnt, red_cnt, blue_cnt;   // counts including the held pixel

  assign hit_green = is_dominant(s1_green_r, s1_red_r,   s1_blue_r,  green_level_min_r);
  assign hit_red   = is_dominant(s1_red_r,   s1_green_r, s1_blue_r,  red_level_min_r);
  assign hit_blue  = is_dominant(s1_blue_r,  s1_red_r,   s1_green_r, blue_level_min_r);

  assign green_cnt = (hit_green && green_tally_r != COUNT_MAX) ? green_tally_r + 1'b1
                                                               : green_tally_r;
  assign red_cnt   = (hit_red && red_tally_r != COUNT_MAX) ? red_tally_r + 1'b1
                                                           : red_tally_r;
  assign blue_cnt  = (hit_blue && blue_tally_r != COUNT_MAX) ? blue_tally_r + 1'b1
                                                             : blue_tally_r;

  // Counters: count matching pixels, saturating; clear after the frame's last pixel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      green_tally_r <= '0;
      red_tally_r   <= '0;
      blue_tally_r  <= '0;
    end else if (s1_adv) begin
      if (s1_frame_end_r) begin
        green_tally_r <= '0;
        red_tally_r   <= '0;
        blue_tally_r  <= '0;
      end else begin
        green_tally_r <= green_cnt;
        red_tally_r   <= red_cnt;
        blue_tally_r  <= blue_cnt;
      end
    end
  end

  // Pick the class: green wins over red, red over blue.
  color_t color_nxt;

  always_comb begin
    if (CMP_W'(green_cnt) > CMP_W'(green_count_min_r)) begin
      color_nxt = COLOR_GREEN;
    end else if (CMP_W'(red_cnt) > CMP_W'(red_count_min_r)) begin
      color_nxt = COLOR_RED;
    end else if (CMP_W'(blue_cnt) > CMP_W'(blue_count_min_r)) begin
      color_nxt = COLOR_BLUE;
    end else begin
      color_nxt = COLOR_NONE;
    end
  end

  // Result register.
  logic load_out;
  assign load_out = s1_adv && s1_frame_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Totals carry the low bits of the count, zero-extended for narrow counters.
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_detected_color <= color_nxt;
      out_green_total    <= TOTAL_W'(green_cnt);
      out_red_total      <= TOTAL_W'(red_cnt);
      out_blue_total     <= TOTAL_W'(blue_cnt);
    end
  end

endmodule

`default_nettype wire

### sv/rcpc_checker.sv
// Port-level checker for the pixel counter, bound to the top level.
`default_nettype none

module rcpc_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire rcpc_pkg::color_t    out_detected_color,
  input wire rcpc_pkg::total_t    out_green_total,
  input wire rcpc_pkg::total_t    out_red_total,
  input wire rcpc_pkg::total_t    out_blue_total
);
  import rcpc_pkg::*;

  // No result may show right after reset.
  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // Input backpressure only comes from a stalled, full result register.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a stalled result");

  // A stalled result stays offered.
  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> ($stable(out_detected_color) && $stable(out_green_total)
                                  && $stable(out_red_total) && $stable(out_blue_total)))
    else $error("result payload changed while stalled");

endmodule

bind rgb_color_pixel_counter rcpc_checker u_rcpc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_detected_color (out_detected_color),
  .out_green_total    (out_green_total),
  .out_red_total      (out_red_total),
  .out_blue_total     (out_blue_total)
);

`default_nettype wire
